// ----- src/risc_subset_single_cycle_core_macros.svh -----
// assertion macros shared by the core's rtl files
// no dependencies; included by the top level only
`ifndef RISC_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH
`define RISC_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH

// same-cycle implication, masked while reset is high
`define RSC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, not masked by reset
`define RSC_ASSERT_AFTER(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/rsc_pkg.sv -----
// shared types, opcode and funct constants and control decode for the core
// no dependencies; imported by rsc_exec and the top level
package rsc_pkg;

  localparam int unsigned DATA_DEPTH_DEF = 1024;
  localparam int unsigned PROGRAM_DEPTH  = 1024;
  localparam int unsigned RF_DEPTH       = 32;

  localparam logic [5:0] OP_RTYPE  = 6'b000000;
  localparam logic [5:0] FUNCT_ADD = 6'b100000;
  localparam logic [5:0] FUNCT_SUB = 6'b100010;
  localparam logic [5:0] FUNCT_SLT = 6'b101010;

  typedef struct packed {
    logic regdst;
    logic alusrc;
    logic mem2reg;
    logic regwr;
    logic memrd;
    logic memwr;
    logic branch;
    logic jump;
  } ctrl_t;

  typedef struct packed {
    ctrl_t       ctrl;
    logic [31:0] alu;
    logic [31:0] next_pc;
    logic [4:0]  dest;
    logic        wen;
  } exec_t;

  // control lines straight from the opcode bits
  function automatic ctrl_t decode(input logic [5:0] op);
    ctrl_t c;
    c.regdst  = !op[3] && !op[2] && !op[1];
    c.alusrc  = op[3] || op[0];
    c.mem2reg = !op[3] && op[0];
    c.regwr   = (!op[2] && !op[1]) || (!op[3] && op[0]);
    c.memrd   = !op[3] && op[0];
    c.memwr   = op[3] && op[0];
    c.branch  = op[2];
    c.jump    = !op[5] && op[1];
    return c;
  endfunction

endpackage

// ----- src/rsc_ram.sv -----
// generic single write port ram with one registered read port (read-old)
// no dependencies
module rsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/rsc_exec.sv -----
// execute logic: decode, alu, destination select and next pc
// depends on rsc_pkg
module rsc_exec import rsc_pkg::*; (
  input  logic [31:0] instruction,
  input  logic [31:0] pc,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output exec_t       res
);

  logic [5:0]  op;
  logic [5:0]  funct;
  logic [31:0] imm;
  logic [31:0] opnd2;
  logic [31:0] pc_inc;

  always_comb begin
    op     = instruction[31:26];
    funct  = instruction[5:0];
    imm    = {{16{instruction[15]}}, instruction[15:0]};
    res.ctrl = decode(op);
    opnd2  = res.ctrl.alusrc ? imm : op_b;

    if (op == OP_RTYPE) begin
      unique case (funct)
        FUNCT_SUB: res.alu = op_a - op_b;
        FUNCT_SLT: res.alu = {31'b0, ($signed(op_a) < $signed(op_b))};
        FUNCT_ADD: res.alu = op_a + op_b;
        default:   res.alu = op_a + op_b;  // unknown funct adds
      endcase
    end else begin
      res.alu = op_a + opnd2;
    end

    pc_inc = pc + 32'd1;
    if (res.ctrl.jump) begin
      res.next_pc = {6'b0, instruction[25:0]};
    end else if (res.ctrl.branch && (op_a == op_b)) begin
      res.next_pc = pc_inc + imm;
    end else begin
      res.next_pc = pc_inc;
    end

    res.dest = res.ctrl.regdst ? instruction[15:11] : instruction[20:16];
    res.wen  = res.ctrl.regwr && (res.dest != 5'd0);
  end

endmodule

// ----- src/risc_subset_single_cycle_core.sv -----
// top level of the single-cycle integer core: pipeline, state and stream ports
// depends on rsc_pkg, rsc_ram, rsc_exec and the assertion macro header
//
// usage: each beat on the s_t* channel is one 32-bit instruction word, the word
// at the current pc. the core executes it against its own register file and
// data memory and sends one result beat on the m_t* channel: next pc, halt
// flag, the register write and the memory store or load address.
// program_length is written on the cfg channel (always ready) while idle.
// a result beat passes stage 1, stage 2 and the output register after its
// instruction is accepted. throughput: one instruction per cycle, back to
// back, while the receiver keeps up; ram read stages are bypassed so dependent
// instructions need no bubbles. a whole-pipeline enable (output register empty
// or being taken) moves every stage; when the receiver holds m_tready low the
// output holds and s_tready drops once the output register is full.
// reset: clears pc, program_length and valid bits, then a clearing pass
// zeroes data memory and register file with s_tready low. DATA_DEPTH must
// be a power of two.
`include "risc_subset_single_cycle_core_macros.svh"

module risc_subset_single_cycle_core import rsc_pkg::*; #(
  parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // instruction stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // instruction
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // next_pc[31:0], halted[32], reg_write_index[37:33],
  // reg_write_value[69:38], mem_address[79:70], mem_write_data[111:80]
  output logic [111:0] m_tdata,
  // reg_write_enable[0], mem_write_enable[1]
  output logic [1:0]   m_tuser,
  // program_length write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [10:0]  cfg_data
);

  localparam int unsigned AW        = $clog2(DATA_DEPTH);
  localparam int unsigned CLR_DEPTH = (DATA_DEPTH > RF_DEPTH) ? DATA_DEPTH : RF_DEPTH;
  localparam int unsigned CW        = $clog2(CLR_DEPTH);
  localparam int unsigned RF_AW     = $clog2(RF_DEPTH);

  // control
  logic          clr_busy;
  logic [CW-1:0] clr_cnt;
  logic [10:0]   prog_len;
  logic [31:0]   pc;
  logic          adv;
  logic          accept;

  // stage 1: instruction with register file read in flight
  logic          s1_valid;
  logic [31:0]   s1_ins;
  logic [31:0]   op_a;
  logic [31:0]   op_b;
  exec_t         ex;
  logic [AW-1:0] s1_addr;

  // stage 2: executed, load data in flight
  logic          s2_valid;
  logic          s2_wen;
  logic [4:0]    s2_dest;
  logic [31:0]   s2_alu;
  logic          s2_mem2reg;
  logic          s2_memrd;
  logic          s2_memwr;
  logic [AW-1:0] s2_addr;
  logic [31:0]   s2_b;
  logic [31:0]   s2_next_pc;
  logic [31:0]   s2_wval;
  logic          s2_halted;

  // output register
  logic          out_valid;
  logic [31:0]   out_next_pc;
  logic          out_halted;
  logic          out_wen;
  logic [4:0]    out_dest;
  logic [31:0]   out_wval;
  logic          out_memwr;
  logic [9:0]    out_addr;
  logic [31:0]   out_wdata;

  // ram ports
  logic             rf_we;
  logic [RF_AW-1:0] rf_waddr;
  logic [31:0]      rf_wdata;
  logic [31:0]      rf_a_rdata;
  logic [31:0]      rf_b_rdata;
  logic             dm_we;
  logic [AW-1:0]    dm_waddr;
  logic [31:0]      dm_wdata;
  logic             dm_re;
  logic [31:0]      dm_rdata;

  logic [10:0]      prog_len_next;

  // whole pipeline moves when the output register is empty or being taken
  assign adv       = !out_valid || m_tready;
  assign s_tready  = adv && !clr_busy;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // program_length above the program depth counts as the depth
  assign prog_len_next = ({21'b0, cfg_data} > 32'(PROGRAM_DEPTH)) ?
                         11'(PROGRAM_DEPTH) : cfg_data;

  // clearing pass and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
      prog_len <= '0;
    end else begin
      if (clr_busy) begin
        if (clr_cnt == CW'(CLR_DEPTH - 1)) begin
          clr_busy <= 1'b0;
        end
        clr_cnt <= clr_cnt + CW'(1);
      end
      if (cfg_valid) begin
        prog_len <= prog_len_next;
      end
    end
  end

  // register file: two copies, one per read port, written together
  assign rf_we    = clr_busy ? ({1'b0, clr_cnt} < (CW + 1)'(RF_DEPTH))
                             : (s2_valid && adv && s2_wen);
  assign rf_waddr = clr_busy ? clr_cnt[RF_AW-1:0] : s2_dest;
  assign rf_wdata = clr_busy ? 32'd0 : s2_wval;

  rsc_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (accept),
    .raddr (s_tdata[25:21]),
    .rdata (rf_a_rdata)
  );

  rsc_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (accept),
    .raddr (s_tdata[20:16]),
    .rdata (rf_b_rdata)
  );

  // stage 2 write value; a load takes the data memory read here
  assign s2_wval = s2_mem2reg ? dm_rdata : s2_alu;

  // operand bypass: stage 2 is youngest, then the output register, then the ram
  always_comb begin
    if (s2_valid && s2_wen && (s2_dest == s1_ins[25:21])) begin
      op_a = s2_wval;
    end else if (out_valid && out_wen && (out_dest == s1_ins[25:21])) begin
      op_a = out_wval;
    end else begin
      op_a = rf_a_rdata;
    end
    if (s2_valid && s2_wen && (s2_dest == s1_ins[20:16])) begin
      op_b = s2_wval;
    end else if (out_valid && out_wen && (out_dest == s1_ins[20:16])) begin
      op_b = out_wval;
    end else begin
      op_b = rf_b_rdata;
    end
  end

  rsc_exec u_exec (
    .instruction (s1_ins),
    .pc          (pc),
    .op_a        (op_a),
    .op_b        (op_b),
    .res         (ex)
  );

  // word address wraps at the memory depth
  assign s1_addr = ex.alu[AW-1:0];

  // data memory: stores land as the store leaves stage 1, loads read then too
  assign dm_we    = clr_busy ? 1'b1 : (s1_valid && adv && ex.ctrl.memwr);
  assign dm_waddr = clr_busy ? clr_cnt[AW-1:0] : s1_addr;
  assign dm_wdata = clr_busy ? 32'd0 : op_b;
  assign dm_re    = s1_valid && adv && ex.ctrl.memrd;

  rsc_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dm (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (s1_addr),
    .rdata (dm_rdata)
  );

  // halt check on the registered next pc
  assign s2_halted = s2_next_pc[31] || (s2_next_pc >= {21'b0, prog_len});

  // pipeline valids and pc
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
    end else if (adv) begin
      s1_valid  <= accept;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
      if (s1_valid) begin
        pc <= ex.next_pc;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ins <= s_tdata;
    end
    if (adv) begin
      s2_wen      <= ex.wen;
      s2_dest     <= ex.dest;
      s2_alu      <= ex.alu;
      s2_mem2reg  <= ex.ctrl.mem2reg;
      s2_memrd    <= ex.ctrl.memrd;
      s2_memwr    <= ex.ctrl.memwr;
      s2_addr     <= s1_addr;
      s2_b        <= op_b;
      s2_next_pc  <= ex.next_pc;

      out_next_pc <= s2_next_pc;
      out_halted  <= s2_halted;
      out_wen     <= s2_wen;
      out_dest    <= s2_wen ? s2_dest : 5'd0;
      out_wval    <= s2_wen ? s2_wval : 32'd0;
      out_memwr   <= s2_memwr;
      out_addr    <= (s2_memrd || s2_memwr) ? 10'(s2_addr) : 10'd0;
      out_wdata   <= s2_memwr ? s2_b : 32'd0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_wdata, out_addr, out_wval, out_dest, out_halted, out_next_pc};
  assign m_tuser  = {out_memwr, out_wen};

  // checks
  `RSC_ASSERT_IMPLIES(a_no_r0_write, clk, rst, m_tvalid && m_tuser[0],
                      m_tdata[37:33] != 5'd0, "write to register zero reported")
  `RSC_ASSERT_IMPLIES(a_no_store_data, clk, rst, m_tvalid && !m_tuser[1],
                      m_tdata[111:80] == 32'd0, "store data reported without a store")
  `RSC_ASSERT_IMPLIES(a_no_work_in_clear, clk, rst, clr_busy,
                      !s1_valid && !s2_valid && !out_valid, "item in flight during clear")
  `RSC_ASSERT_AFTER(a_reset_quiet, clk, rst, !m_tvalid && !s_tready,
                    "core not quiet after reset")

endmodule
